### hw/rtl/bfsp_pkg.sv
// bfsp_pkg: shared widths, register codes, sequencer states and relax-unit structs
// for the shortest-path unit. no dependencies.
`timescale 1ns / 1ps

package bfsp_pkg;

   localparam int VERT_W       = 6;
   localparam int MAX_VERTICES = 64;
   localparam int VCOUNT_W     = 7;
   localparam int WEIGHT_W     = 16;
   localparam int DIST_W       = 22;
   localparam int SUM_W        = 23;
   localparam int EDGE_W       = 2 * VERT_W + WEIGHT_W;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
   localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

   // register index, taken from the word address bit
   localparam logic REG_VERTEX_COUNT  = 1'b0;
   localparam logic REG_SOURCE_VERTEX = 1'b1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_INIT,
      ST_FETCH,
      ST_DREAD,
      ST_EXEC,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } seq_state_type;

   typedef struct packed {
      logic                       to_known;
      logic signed [DIST_W-1:0]   dist_from;
      logic signed [DIST_W-1:0]   dist_to;
      logic signed [WEIGHT_W-1:0] weight;
   } relax_op_type;

   typedef struct packed {
      logic                     improve;
      logic signed [DIST_W-1:0] dist_new;
   } relax_res_type;

   function automatic logic [VCOUNT_W-1:0] live_count(input logic [VCOUNT_W-1:0] vc);
      logic [VCOUNT_W-1:0] n;
      n = vc;
      if (vc == '0) begin
         n = VCOUNT_W'(1);
      end else if (vc > VCOUNT_W'(MAX_VERTICES)) begin
         n = VCOUNT_W'(MAX_VERTICES);
      end
      return n;
   endfunction

endpackage

### hw/rtl/bfsp_relax_unit.sv
// bfsp_relax_unit: the shared add / compare / saturate unit used for every edge visit.
// depends on bfsp_pkg.
`timescale 1ns / 1ps

module bfsp_relax_unit
   import bfsp_pkg::*;
(
   input  relax_op_type  op,
   output relax_res_type res
);

   logic signed [SUM_W-1:0] sum;
   logic signed [SUM_W-1:0] dist_to_ext;

   assign sum         = SUM_W'(op.dist_from) + SUM_W'(op.weight);
   assign dist_to_ext = SUM_W'(op.dist_to);

   always_comb begin
      // compare on the unsaturated sum so saturation cannot mask a cycle
      res.improve = !op.to_known || (sum < dist_to_ext);
      priority if (sum > SUM_W'(DIST_MAX)) begin
         res.dist_new = DIST_MAX;
      end else if (sum < SUM_W'(DIST_MIN)) begin
         res.dist_new = DIST_MIN;
      end else begin
         res.dist_new = sum[DIST_W-1:0];
      end
   end

endmodule

### hw/rtl/bellman_ford_shortest_paths_unit.sv
// bellman_ford_shortest_paths_unit: edge store, distance memory and run sequencer.
// depends on bfsp_pkg and bfsp_relax_unit.
`timescale 1ns / 1ps
//
// Usage:
//   req_* stream carries edges, one per beat. tuser is has_edge; a beat with
//   tuser low carries no edge. tlast marks the final beat and starts a run.
//   Edges load at one per cycle while req_tready is high; beyond MAX_EDGES
//   they are dropped.
//   A run has a setup step, then n passes over the E stored edges, each edge
//   taking an edge memory read, a distance memory read and an add/compare/
//   write in the one relax unit, where n is the vertex count saturated to
//   1..64. Then n results follow on rsp_*, each a distance memory read, then
//   the held result beat; the next read starts only after a beat is taken.
//   req_tready stays low from the last edge until the final result is taken.
//   A stalled result beat is held unchanged until rsp_tready.
//   csr_* is an APB-style port: vertex_count at 0x0, source_vertex at 0x4;
//   write only while the block is idle.
//   Reset: vertex_count 64, source_vertex 0, edge store empty, block idle.

module bellman_ford_shortest_paths_unit
   import bfsp_pkg::*;
#(
   parameter int MAX_EDGES = 1024
)(
   input  logic                  clock,
   input  logic                  reset,
   // slave side
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // from_vertex[5:0], to_vertex[11:6],
                                              // edge_weight[27:12], zero fill
   input  logic                  req_tuser,   // has_edge
   input  logic                  req_tlast,   // last_edge
   // master side
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // vertex[5:0], distance[27:6], zero fill
   output logic [1:0]            rsp_tuser,   // reachable[0], negative_cycle[1]
   output logic                  rsp_tlast,   // last_result
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECNT_W = $clog2(MAX_EDGES + 1);

   seq_state_type state_ff, state_in;

   logic [VCOUNT_W-1:0] vcount_ff;
   logic [VERT_W-1:0]   src_ff;
   logic                csr_wr;

   logic [ECNT_W-1:0]   total_ff;
   logic [EIDX_W-1:0]   idx_ff;
   logic [VCOUNT_W-1:0] pass_ff;
   logic [VCOUNT_W-1:0] n_ff;
   logic [VERT_W-1:0]   k_ff;
   logic                neg_ff;
   logic [MAX_VERTICES-1:0] reach_ff;

   logic [EDGE_W-1:0]   edge_mem [MAX_EDGES];
   logic [EDGE_W-1:0]   edge_rd_ff;
   logic signed [DIST_W-1:0] dist_mem [MAX_VERTICES];
   logic signed [DIST_W-1:0] dist_a_ff;
   logic signed [DIST_W-1:0] dist_b_ff;

   logic                req_beat, rsp_beat, store_en;
   logic                edge_rd_en, dist_rd_en, emit_sel;
   logic                check_mode, last_idx, last_k, edge_ok;
   logic                dist_wr_en;
   logic [VERT_W-1:0]   dist_wr_addr, dist_rd_addr;
   logic signed [DIST_W-1:0] dist_wr_data;
   logic [VCOUNT_W-1:0] n_live;
   logic [VERT_W-1:0]   e_from, e_to;
   logic signed [WEIGHT_W-1:0] e_weight;
   relax_op_type        rop;
   relax_res_type       rres;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= VCOUNT_W'(MAX_VERTICES);
         src_ff    <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_VERTEX_COUNT:  vcount_ff <= csr_pwdata[VCOUNT_W-1:0];
            REG_SOURCE_VERTEX: src_ff    <= csr_pwdata[VERT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_VERTEX_COUNT:  csr_prdata = CSR_DATA_W'(vcount_ff);
         REG_SOURCE_VERTEX: csr_prdata = CSR_DATA_W'(src_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // edge fields of the fetched entry
   assign e_from   = edge_rd_ff[EDGE_W-1 -: VERT_W];
   assign e_to     = edge_rd_ff[WEIGHT_W +: VERT_W];
   assign e_weight = edge_rd_ff[WEIGHT_W-1:0];

   assign n_live     = live_count(vcount_ff);
   assign check_mode = (pass_ff == n_ff);
   assign last_idx   = (ECNT_W'(idx_ff) == total_ff - ECNT_W'(1));
   assign last_k     = (VCOUNT_W'(k_ff) + VCOUNT_W'(1) == n_ff);
   assign edge_ok    = (VCOUNT_W'(e_from) < n_ff) && (VCOUNT_W'(e_to) < n_ff)
                       && reach_ff[e_from];

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;
   assign store_en = req_beat && req_tuser && (total_ff < ECNT_W'(MAX_EDGES));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:     if (req_beat && req_tlast) state_in = ST_INIT;
         ST_INIT:     state_in = (total_ff == '0) ? ST_EMIT_RD : ST_FETCH;
         ST_FETCH:    state_in = ST_DREAD;
         ST_DREAD:    state_in = ST_EXEC;
         ST_EXEC:     state_in = (last_idx && check_mode) ? ST_EMIT_RD : ST_FETCH;
         ST_EMIT_RD:  state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: if (rsp_beat) state_in = last_k ? ST_LOAD : ST_EMIT_RD;
         default:     state_in = ST_LOAD;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      edge_rd_en = 1'b0;
      dist_rd_en = 1'b0;
      emit_sel   = 1'b0;
      unique case (state_ff)
         ST_LOAD:     req_tready = 1'b1;
         ST_FETCH:    edge_rd_en = 1'b1;
         ST_DREAD:    dist_rd_en = 1'b1;
         ST_EMIT_RD: begin
            dist_rd_en = 1'b1;
            emit_sel   = 1'b1;
         end
         ST_EMIT_OUT: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // shared relax unit
   assign rop.to_known  = reach_ff[e_to];
   assign rop.dist_from = dist_a_ff;
   assign rop.dist_to   = dist_b_ff;
   assign rop.weight    = e_weight;

   bfsp_relax_unit u_relax (
      .op  (rop),
      .res (rres)
   );

   // edge store
   always_ff @(posedge clock) begin
      if (store_en) begin
         edge_mem[total_ff[EIDX_W-1:0]] <= {req_tdata[5:0], req_tdata[11:6], req_tdata[27:12]};
      end
      if (edge_rd_en) begin
         edge_rd_ff <= edge_mem[idx_ff];
      end
   end

   // distance memory: source is seeded at run setup, relaxes write the head vertex
   assign dist_wr_en   = (state_ff == ST_INIT) ||
                         ((state_ff == ST_EXEC) && !check_mode && edge_ok && rres.improve);
   assign dist_wr_addr = (state_ff == ST_INIT) ? src_ff : e_to;
   assign dist_wr_data = (state_ff == ST_INIT) ? '0 : rres.dist_new;
   assign dist_rd_addr = emit_sel ? k_ff : e_from;

   always_ff @(posedge clock) begin
      if (dist_wr_en) begin
         dist_mem[dist_wr_addr] <= dist_wr_data;
      end
      if (dist_rd_en) begin
         dist_a_ff <= dist_mem[dist_rd_addr];
         dist_b_ff <= dist_mem[e_to];
      end
   end

   // run control
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         idx_ff   <= '0;
         pass_ff  <= '0;
         n_ff     <= VCOUNT_W'(1);
         k_ff     <= '0;
         neg_ff   <= 1'b0;
         reach_ff <= '0;
      end else begin
         if (store_en) begin
            total_ff <= total_ff + ECNT_W'(1);
         end
         unique case (state_ff)
            ST_INIT: begin
               n_ff     <= n_live;
               pass_ff  <= VCOUNT_W'(1);
               idx_ff   <= '0;
               k_ff     <= '0;
               neg_ff   <= 1'b0;
               // only an in-range source starts out reachable
               reach_ff <= (VCOUNT_W'(src_ff) < n_live) ? (MAX_VERTICES'(1) << src_ff) : '0;
            end
            ST_EXEC: begin
               if (edge_ok && rres.improve) begin
                  if (check_mode) begin
                     neg_ff <= 1'b1;
                  end else begin
                     reach_ff[e_to] <= 1'b1;
                  end
               end
               if (last_idx) begin
                  idx_ff  <= '0;
                  pass_ff <= pass_ff + VCOUNT_W'(1);
               end else begin
                  idx_ff <= idx_ff + EIDX_W'(1);
               end
            end
            ST_EMIT_OUT: begin
               if (rsp_beat) begin
                  k_ff <= k_ff + VERT_W'(1);
                  if (last_k) begin
                     total_ff <= '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // result beat, built from registered state only
   assign rsp_tdata = {{(32 - VERT_W - DIST_W){1'b0}},
                       (reach_ff[k_ff] ? dist_a_ff : {DIST_W{1'b0}}), k_ff};
   assign rsp_tuser = {neg_ff, reach_ff[k_ff]};
   assign rsp_tlast = last_k;

   // checks
   a_sides_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and result sides active together");

   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("still accepting edges after the final beat");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && total_ff == '0))
      else $error("edge store not released after the final result");

   a_neg_in_check: assert property (@(posedge clock) disable iff (reset)
      $rose(neg_ff) |-> ($past(state_ff) == ST_EXEC && $past(check_mode)))
      else $error("cycle flag set outside the check pass");

endmodule

### tb/sv/tb.sv
// tb: self-checking bench for bellman_ford_shortest_paths_unit; loads edge graphs on req_*,
// solves them in a shadow predictor and checks every per-vertex distance beat on rsp_*.
// depends on bfsp_pkg and the unit's rtl; vertex count and source are set over csr_*.
`timescale 1ns / 1ps

module tb;
   import bfsp_pkg::*;

   localparam int EDGE_DEPTH = 1024;
   localparam logic [CSR_ADDR_W-1:0] ADDR_VERTEX_COUNT  = {REG_VERTEX_COUNT, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_SOURCE_VERTEX = {REG_SOURCE_VERTEX, 2'b00};

   typedef struct {
      bit                has_edge;
      bit [VERT_W-1:0]   from_v;
      bit [VERT_W-1:0]   to_v;
      bit [WEIGHT_W-1:0] weight;
      bit                last;
      bit                drain_first;   // hold until every pending distance has come back
   } edge_beat_type;

   typedef struct {
      bit [VERT_W-1:0] vertex;
      bit [DIST_W-1:0] distance;
      bit              reachable;
      bit              neg_cycle;
      bit              last;
   } vertex_dist_type;

   typedef enum {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} ready_mode_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata   = '0;   // from_vertex[5:0], to_vertex[11:6],
                                              // edge_weight[27:12], zero fill
   logic                  req_tuser   = 1'b0; // has_edge
   logic                  req_tlast   = 1'b0; // last_edge
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [31:0]           rsp_tdata;          // vertex[5:0], distance[27:6], zero fill
   logic [1:0]            rsp_tuser;          // reachable[0], negative_cycle[1]
   logic                  rsp_tlast;          // last_result
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow of the unit: stored graph, register copies, distances still owed
   bit [VERT_W-1:0]          graph_from   [EDGE_DEPTH];
   bit [VERT_W-1:0]          graph_to     [EDGE_DEPTH];
   bit signed [WEIGHT_W-1:0] graph_weight [EDGE_DEPTH];
   int unsigned              graph_edges      = 0;
   bit [VCOUNT_W-1:0]        cfg_vertex_count = VCOUNT_W'(MAX_VERTICES);
   bit [VERT_W-1:0]          cfg_source       = '0;
   vertex_dist_type          expected_dists[$];
   edge_beat_type            edge_feed[$];
   int                       error_count = 0;

   edge_beat_type  cur_beat;
   int             burst_left = 0;
   int             gap_left   = 0;
   ready_mode_type ready_mode = RDY_ALWAYS;
   int             mode_left  = 0;
   int             tick_cnt   = 0;
   vertex_dist_type want;

   bellman_ford_shortest_paths_unit #(
      .MAX_EDGES (EDGE_DEPTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // n-1 relaxing sweeps in load order, then one sweep that only looks for a cycle
   function automatic void solve_shortest_paths();
      int              n;
      longint          reach_dist [MAX_VERTICES];
      bit              known [MAX_VERTICES];
      bit              neg;
      longint          sum;
      int              u;
      int              v;
      vertex_dist_type res;
      n = (cfg_vertex_count == 0) ? 1 :
          (cfg_vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(cfg_vertex_count);
      neg = 1'b0;
      for (int k = 0; k < MAX_VERTICES; k++) begin
         reach_dist[k] = 0;
         known[k] = 1'b0;
      end
      if (cfg_source < n)
         known[cfg_source] = 1'b1;
      for (int sweep = 1; sweep <= n; sweep++) begin
         for (int i = 0; i < graph_edges; i++) begin
            u = graph_from[i];
            v = graph_to[i];
            if (u < n && v < n && known[u]) begin
               // compare the unsaturated sum so clamping cannot hide a cycle
               sum = reach_dist[u] + longint'(graph_weight[i]);
               if (!known[v] || sum < reach_dist[v]) begin
                  if (sweep == n) begin
                     neg = 1'b1;
                  end else begin
                     reach_dist[v] = (sum > DIST_MAX) ? longint'(DIST_MAX) :
                                     (sum < DIST_MIN) ? longint'(DIST_MIN) : sum;
                     known[v] = 1'b1;
                  end
               end
            end
         end
      end
      for (int k = 0; k < n; k++) begin
         res.vertex    = VERT_W'(k);
         res.reachable = known[k];
         res.distance  = known[k] ? reach_dist[k][DIST_W-1:0] : '0;
         res.neg_cycle = neg;
         res.last      = (k == n - 1);
         expected_dists = {expected_dists, res};
      end
      graph_edges = 0;
   endfunction

   function automatic void absorb_edge_beat(input edge_beat_type b);
      if (b.has_edge && graph_edges < EDGE_DEPTH) begin
         graph_from[graph_edges]   = b.from_v;
         graph_to[graph_edges]     = b.to_v;
         graph_weight[graph_edges] = b.weight;
         graph_edges++;
      end
      if (b.last)
         solve_shortest_paths();
   endfunction

   function automatic void push_beat(input bit has_edge, input int from_v, input int to_v,
                                     input int weight, input bit last, input bit drain_first);
      edge_beat_type b;
      b.has_edge    = has_edge;
      b.from_v      = VERT_W'(from_v);
      b.to_v        = VERT_W'(to_v);
      b.weight      = WEIGHT_W'(weight);
      b.last        = last;
      b.drain_first = drain_first;
      edge_feed = {edge_feed, b};
   endfunction

   // mostly in-range edges with small weights, plus out-of-range ends and empty beats
   function automatic edge_beat_type random_beat(input int n, input bit last);
      edge_beat_type b;
      int            pick;
      int            w;
      pick          = $urandom_range(0, 99);
      b.has_edge    = 1'b1;
      b.last        = last;
      b.drain_first = 1'b0;
      b.from_v      = VERT_W'($urandom_range(0, n - 1));
      b.to_v        = VERT_W'($urandom_range(0, n - 1));
      case ($urandom_range(0, 5))
         0, 1, 2: w = $urandom_range(0, 40) - 10;
         3, 4:    w = $urandom_range(0, 3000) - 1000;
         default: w = $urandom;
      endcase
      b.weight = WEIGHT_W'(w);
      if (pick < 8 || last && pick < 50) begin
         b.has_edge = 1'b0;
         b.from_v   = VERT_W'($urandom);
         b.to_v     = VERT_W'($urandom);
      end else if (pick < 18 && n < MAX_VERTICES) begin
         if (pick < 13)
            b.from_v = VERT_W'($urandom_range(n, MAX_VERTICES - 1));
         else
            b.to_v = VERT_W'($urandom_range(n, MAX_VERTICES - 1));
      end
      return b;
   endfunction

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input int data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= CSR_DATA_W'(data);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_config(input int vc, input int src);
      csr_write(ADDR_VERTEX_COUNT, vc);
      csr_write(ADDR_SOURCE_VERTEX, src);
      cfg_vertex_count = VCOUNT_W'(vc);
      cfg_source       = VERT_W'(src);
   endtask

   task automatic wait_idle();
      while (edge_feed.size() != 0 || req_tvalid || expected_dists.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // sender: bursts of beats with random gaps, fed from edge_feed
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_tvalid && req_tready)
            absorb_edge_beat(cur_beat);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (edge_feed.size() != 0 &&
                         !(edge_feed[0].drain_first && expected_dists.size() != 0)) begin
               cur_beat = edge_feed.pop_front();
               req_tdata  <= {4'b0, cur_beat.weight, cur_beat.to_v, cur_beat.from_v};
               req_tuser  <= cur_beat.has_edge;
               req_tlast  <= cur_beat.last;
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                           : $urandom_range(0, 12);
                  gap_left   = $urandom_range(0, 4);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each distance beat and stalls on its own pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         mode_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_dists.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: unexpected distance beat, vertex %0d", $realtime,
                           rsp_tdata[VERT_W-1:0]);
               error_count++;
            end else begin
               want = expected_dists.pop_front();
               if (rsp_tdata[VERT_W-1:0] !== want.vertex ||
                   rsp_tdata[VERT_W +: DIST_W] !== want.distance ||
                   rsp_tuser[0] !== want.reachable || rsp_tuser[1] !== want.neg_cycle ||
                   rsp_tlast !== want.last) begin
                  if (error_count < 10)
                     $display({"%0t: mismatch: expected vertex %0d dist %0d reach %0b neg %0b",
                               " last %0b, got vertex %0d dist %0d reach %0b neg %0b last %0b"},
                              $realtime, want.vertex, $signed(want.distance), want.reachable,
                              want.neg_cycle, want.last, rsp_tdata[VERT_W-1:0],
                              $signed(rsp_tdata[VERT_W +: DIST_W]), rsp_tuser[0],
                              rsp_tuser[1], rsp_tlast);
                  error_count++;
               end
            end
         end
         tick_cnt++;
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            RDY_ALWAYS:   rsp_tready <= 1'b1;
            RDY_COIN:     rsp_tready <= ($urandom_range(0, 1) == 1);
            RDY_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
            default:      rsp_tready <= (tick_cnt % 5 == 0);
         endcase
      end
   end

   initial begin
      int            random_beats;
      int            vc;
      int            src;
      int            n_live;
      int            graphs;
      int            edges;
      bit            big;
      edge_beat_type b;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // weight extremes, an empty beat and out-of-range ends; second graph waits for drain
      set_config(4, 0);
      push_beat(1, 0, 1, 32767, 0, 0);
      push_beat(0, 63, 63, -1, 0, 0);
      push_beat(1, 1, 2, -32768, 0, 0);
      push_beat(1, 0, 10, 3, 0, 0);
      push_beat(1, 9, 3, -7, 0, 0);
      push_beat(1, 2, 3, 5, 1, 0);
      push_beat(1, 0, 2, -2, 0, 1);
      push_beat(0, 0, 0, 0, 1, 0);
      wait_idle();

      // single vertex with an empty graph, zero count, then the saturated count
      set_config(1, 0);
      push_beat(0, 0, 0, 0, 1, 0);
      wait_idle();
      set_config(0, 0);
      push_beat(1, 0, 0, -1, 1, 0);
      wait_idle();
      set_config(127, 63);
      push_beat(1, 63, 62, -32768, 1, 0);
      wait_idle();

      // reachable negative cycle
      set_config(3, 2);
      push_beat(1, 2, 0, 1, 0, 0);
      push_beat(1, 0, 1, -3, 0, 0);
      push_beat(1, 1, 0, 1, 1, 0);
      wait_idle();

      // source beyond the vertex count
      set_config(5, 7);
      push_beat(1, 0, 1, 1, 0, 0);
      push_beat(1, 1, 2, -4, 1, 0);
      wait_idle();

      // negative cycle spun over 63 sweeps drives distances into the floor
      set_config(64, 0);
      push_beat(1, 0, 1, -32768, 0, 0);
      push_beat(1, 1, 0, -32768, 0, 0);
      push_beat(1, 1, 2, 100, 1, 0);
      wait_idle();

      random_beats = 0;
      while (random_beats < 150) begin
         big = ($urandom_range(0, 5) == 0);
         if (big)
            vc = ($urandom_range(0, 2) == 0) ? 127 : $urandom_range(40, 127);
         else
            vc = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
         n_live = (vc == 0) ? 1 : (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
         src = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_VERTICES - 1)
                                           : $urandom_range(0, n_live - 1);
         set_config(vc, src);
         graphs = $urandom_range(1, 3);
         for (int g = 0; g < graphs; g++) begin
            edges = big ? $urandom_range(1, 40) : $urandom_range(0, 3 * n_live);
            for (int e = 0; e <= edges; e++) begin
               b = random_beat(n_live, e == edges);
               if (g > 0 && e == 0)
                  b.drain_first = $urandom_range(0, 1);
               if (b.has_edge || b.last)
                  random_beats++;
               edge_feed = {edge_feed, b};
            end
         end
         wait_idle();
      end

      repeat (100) @(posedge clock);
      if (error_count == 0 && expected_dists.size() == 0)
         $display("[bellman_ford_shortest_paths_unit] OK");
      else
         $display("[bellman_ford_shortest_paths_unit] ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[bellman_ford_shortest_paths_unit] ERROR");
      $finish;
   end

endmodule
